// File: design/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types, constants and helpers of the stereo tanh soft clipper.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int SAMPLE_W_DEF   = 24;
    localparam int TANH_DEPTH_DEF = 256;
    localparam int TANH_ROM_MAX   = 4096;

    localparam int TANH_W        = 24;
    localparam int FRAC_W        = 16;
    localparam int DRIVE_W       = 16;
    localparam int DRIVE_FRAC    = 10;
    localparam int MIX_W         = 17;
    localparam int INV_W         = 18;
    localparam int CFG_DATA_W    = 17;
    localparam int CFG_IDX_W     = 2;
    localparam int TANH_RANGE_SH = 3;
    localparam int WET_SH_BASE   = 40;
    localparam int ROUND_SH      = 32;
    localparam int DIV_W         = 40;
    localparam int REM_W         = TANH_W + 1;
    localparam int N_STAGES      = 9;

    localparam logic [DRIVE_W-1:0] DRIVE_MIN = 16'd1024;
    localparam logic [DRIVE_W-1:0] DRIVE_MAX = 16'd51200;
    localparam logic [DRIVE_W-1:0] DRIVE_RST = 16'd4096;
    localparam logic [MIX_W-1:0]   UNIT_Q16  = 17'd65536;
    localparam logic [MIX_W-1:0]   MIX_RST   = 17'd65536;
    localparam logic [MIX_W-1:0]   LEVEL_RST = 17'd45875;
    localparam logic [INV_W-1:0]   INV_MAX   = 18'h3FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIVE = 2'd0,
        CFG_MIX   = 2'd1,
        CFG_LEVEL = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INDEX,
        ST_READ,
        ST_INTERP,
        ST_DIV
    } t_inv_state;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic [MIX_W-1:0]   mix;
        logic [MIX_W-1:0]   level;
        logic [INV_W-1:0]   inv;
    } t_lane_cfg;

    typedef logic [TANH_W-1:0] t_tanh_rom [TANH_ROM_MAX+1];

    localparam int IP_W = TANH_W + FRAC_W;

    // restoring long division for building constant tables
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        longint unsigned q;
        logic [64:0]     r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh points over [0, 8], Q1.23, from a truncated series for exp(-step)
    function automatic t_tanh_rom tanh_rom(input longint unsigned step, input int depth);
        t_tanh_rom rom;
        longint unsigned one;
        longint unsigned term;
        longint unsigned e;
        longint unsigned num;
        longint unsigned den;
        longint unsigned sum_u;
        longint sum;
        one  = 64'd1 << 32;
        term = one;
        sum  = $signed(one);
        e    = one;
        for (int k = 1; k <= 14; k++) begin
            term = udiv64((term * step) >> 32, 64'(k));
            if ((k & 1) != 0) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        sum_u = $unsigned(sum);
        for (int i = 0; i <= depth; i++) begin
            if (i > 0) begin
                e = (e * sum_u + (64'd1 << 31)) >> 32;
            end
            num    = (one - e) << 23;
            den    = one + e;
            rom[i] = TANH_W'(udiv64(num + (den >> 1), den));
        end
        return rom;
    endfunction

    // linear interpolation between two neighboring points, rounded
    function automatic logic [TANH_W-1:0] tanh_interp(input logic [TANH_W-1:0] a,
                                                     input logic [TANH_W-1:0] b,
                                                     input logic [FRAC_W-1:0] f);
        logic [TANH_W-1:0] d;
        logic [IP_W-1:0]   p;
        d = (b >= a) ? b - a : '0;
        p = IP_W'(d) * IP_W'(f) + (IP_W'(1) << (FRAC_W - 1));
        return a + p[IP_W-1:FRAC_W];
    endfunction

endpackage

// File: design/stereo_tanh_soft_clipper.sv
// ----------------------------------------------------------------------------
// stereo_tanh_soft_clipper
// Normalized tanh soft clip of a stereo frame, wet/dry mix and output level.
//
//   port group     dir   word contents (lsb first)
//   i_s_axis_*     in    left_in, right_in
//   o_m_axis_*     out   left_out, right_out
//   i_cfg_*        in    0 drive_gain, 1 wet_mix, 2 output_level
//
// one frame per cycle while the output takes words and the divider is idle
// after reset and each drive_gain write the 1/tanh(drive) sequencer indexes, reads,
// interpolates and divides (one quotient bit per cycle) with o_s_axis_tready low
// per-stage enables fill bubbles, a stalled output holds the pipe without loss
// ----------------------------------------------------------------------------
module stereo_tanh_soft_clipper #(
    parameter int SAMPLE_WIDTH     = stc_pkg::SAMPLE_W_DEF,
    parameter int TANH_TABLE_DEPTH = stc_pkg::TANH_DEPTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     i_s_axis_tdata,  // left_in, right_in
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     o_m_axis_tdata,  // left_out, right_out
    input  logic                                    i_cfg_we,
    input  logic [stc_pkg::CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [stc_pkg::CFG_DATA_W-1:0]          i_cfg_data
);

    localparam int SW      = SAMPLE_WIDTH;
    localparam int NS      = stc_pkg::N_STAGES;
    localparam int TDATA_W = ((2*SAMPLE_WIDTH+7)/8)*8;
    localparam int IW      = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int DPW     = stc_pkg::DRIVE_W + IW;
    localparam int DSH     = stc_pkg::DRIVE_FRAC + stc_pkg::TANH_RANGE_SH;
    localparam int DXW     = DPW - DSH;
    localparam int CW      = $clog2(stc_pkg::DIV_W + 1);
    localparam longint unsigned TANH_STEP = (64'd16 << 32) / TANH_TABLE_DEPTH;
    localparam stc_pkg::t_tanh_rom ROM_ALL = stc_pkg::tanh_rom(TANH_STEP, TANH_TABLE_DEPTH);
    localparam logic [IW-1:0] IDX_TOP = IW'(TANH_TABLE_DEPTH);

    logic [stc_pkg::TANH_W-1:0] w_tab [TANH_TABLE_DEPTH+1];

    logic [stc_pkg::DRIVE_W-1:0]  r_drive;
    logic [stc_pkg::MIX_W-1:0]    r_mix, r_level;
    logic [stc_pkg::INV_W-1:0]    r_inv;
    logic [NS-1:0]                r_vld;
    logic [NS-1:0]                w_en;
    logic                         w_accept;
    logic                         w_drive_we;
    logic [stc_pkg::DRIVE_W-1:0]  n_drive;
    logic [stc_pkg::MIX_W-1:0]    n_gain;
    stc_pkg::t_lane_cfg           w_cfg;
    logic signed [SW-1:0]         w_left, w_right, w_left_y, w_right_y;

    stc_pkg::t_inv_state          r_state, n_state;
    logic [IW-1:0]                r_ia, r_ib;
    logic [stc_pkg::FRAC_W-1:0]   r_f;
    logic [stc_pkg::TANH_W-1:0]   r_ta, r_tb, r_t;
    logic [stc_pkg::DIV_W-1:0]    r_num;
    logic [stc_pkg::REM_W-1:0]    r_rem;
    logic [CW-1:0]                r_cnt;
    logic [DPW-1:0]               w_dp;
    logic [DXW-1:0]               w_didx;
    logic [stc_pkg::TANH_W-1:0]   w_t;
    logic [stc_pkg::REM_W-1:0]    w_shift;
    logic                         w_ge;

    always_comb begin
        for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
            w_tab[i] = ROM_ALL[i];
        end
    end

    // configuration
    assign w_drive_we = i_cfg_we && (i_cfg_idx == stc_pkg::CFG_DRIVE);

    always_comb begin
        if (i_cfg_data[stc_pkg::DRIVE_W-1:0] < stc_pkg::DRIVE_MIN) begin
            n_drive = stc_pkg::DRIVE_MIN;
        end else if (i_cfg_data[stc_pkg::DRIVE_W-1:0] > stc_pkg::DRIVE_MAX) begin
            n_drive = stc_pkg::DRIVE_MAX;
        end else begin
            n_drive = i_cfg_data[stc_pkg::DRIVE_W-1:0];
        end
        n_gain = (i_cfg_data > stc_pkg::UNIT_Q16) ? stc_pkg::UNIT_Q16 : i_cfg_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive <= stc_pkg::DRIVE_RST;
            r_mix   <= stc_pkg::MIX_RST;
            r_level <= stc_pkg::LEVEL_RST;
        end else if (i_cfg_we) begin
            unique case (stc_pkg::t_cfg_idx'(i_cfg_idx))
                stc_pkg::CFG_DRIVE: begin
                    r_drive <= n_drive;
                end
                stc_pkg::CFG_MIX: begin
                    r_mix <= n_gain;
                end
                stc_pkg::CFG_LEVEL: begin
                    r_level <= n_gain;
                end
                default: begin
                end
            endcase
        end
    end

    // 1/tanh(drive) sequencer
    always_comb begin
        w_dp    = DPW'(r_drive) * DPW'(TANH_TABLE_DEPTH);
        w_didx  = w_dp[DPW-1:DSH];
        w_t     = stc_pkg::tanh_interp(r_ta, r_tb, r_f);
        w_shift = {r_rem[stc_pkg::TANH_W-1:0], r_num[stc_pkg::DIV_W-1]};
        w_ge    = w_shift >= {1'b0, r_t};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stc_pkg::ST_INDEX;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stc_pkg::ST_IDLE: begin
            end
            stc_pkg::ST_INDEX: begin
                n_state = stc_pkg::ST_READ;
            end
            stc_pkg::ST_READ: begin
                n_state = stc_pkg::ST_INTERP;
            end
            stc_pkg::ST_INTERP: begin
                n_state = (w_t == '0) ? stc_pkg::ST_IDLE : stc_pkg::ST_DIV;
            end
            stc_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = stc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stc_pkg::ST_IDLE;
            end
        endcase
        if (w_drive_we) begin
            n_state = stc_pkg::ST_INDEX;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            stc_pkg::ST_INDEX: begin
                if (w_didx >= DXW'(TANH_TABLE_DEPTH)) begin
                    r_ia <= IDX_TOP;
                    r_ib <= IDX_TOP;
                    r_f  <= '0;
                end else begin
                    r_ia <= IW'(w_didx);
                    r_ib <= IW'(w_didx) + IW'(1);
                    r_f  <= stc_pkg::FRAC_W'(w_dp[stc_pkg::TANH_RANGE_SH +: stc_pkg::DRIVE_FRAC])
                            << (stc_pkg::FRAC_W - stc_pkg::DRIVE_FRAC);
                end
            end
            stc_pkg::ST_READ: begin
                r_ta <= w_tab[r_ia];
                r_tb <= w_tab[r_ib];
            end
            stc_pkg::ST_INTERP: begin
                r_t   <= w_t;
                r_num <= (stc_pkg::DIV_W'(1) << (stc_pkg::DIV_W - 1))
                         + stc_pkg::DIV_W'(w_t >> 1);
                r_rem <= '0;
                r_cnt <= CW'(stc_pkg::DIV_W);
                if (w_t == '0) begin
                    r_inv <= stc_pkg::INV_MAX;
                end
            end
            stc_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    r_inv <= (r_num > stc_pkg::DIV_W'(stc_pkg::INV_MAX)) ? stc_pkg::INV_MAX
                             : r_num[stc_pkg::INV_W-1:0];
                end else begin
                    r_rem <= w_ge ? w_shift - {1'b0, r_t} : w_shift;
                    r_num <= {r_num[stc_pkg::DIV_W-2:0], w_ge};
                    r_cnt <= r_cnt - CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // pipeline control
    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || i_m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_s_axis_tready = w_en[0] && (r_state == stc_pkg::ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= w_accept;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign w_cfg   = '{drive: r_drive, mix: r_mix, level: r_level, inv: r_inv};
    assign w_left  = $signed(i_s_axis_tdata[SW-1:0]);
    assign w_right = $signed(i_s_axis_tdata[2*SW-1:SW]);

    stc_lane #(
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
    ) u_lane_left (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_cfg (w_cfg),
        .i_x   (w_left),
        .o_y   (w_left_y)
    );

    stc_lane #(
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
    ) u_lane_right (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_cfg (w_cfg),
        .i_x   (w_right),
        .o_y   (w_right_y)
    );

    assign o_m_axis_tvalid = r_vld[NS-1];
    assign o_m_axis_tdata  = TDATA_W'({w_right_y, w_left_y});

`ifndef SYNTH
    a_drive_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drive_we |=> !o_s_axis_tready)
        else $error("word accepted during inverse recompute");

    a_drive_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drive_we |=> (r_drive >= stc_pkg::DRIVE_MIN && r_drive <= stc_pkg::DRIVE_MAX))
        else $error("drive out of range after write");

    a_gain_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_mix <= stc_pkg::UNIT_Q16 && r_level <= stc_pkg::UNIT_Q16))
        else $error("mix or level out of range after write");
`endif

endmodule

// File: design/stc_lane.sv
// ----------------------------------------------------------------------------
// stc_lane
// One channel of the soft clipper: tanh lookup, 1/tanh(drive) normalization, wet/dry blend, level, saturate.
// ----------------------------------------------------------------------------
module stc_lane #(
    parameter int SAMPLE_WIDTH     = stc_pkg::SAMPLE_W_DEF,
    parameter int TANH_TABLE_DEPTH = stc_pkg::TANH_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic [stc_pkg::N_STAGES-1:0]     i_en,
    input  stc_pkg::t_lane_cfg               i_cfg,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_x,
    output logic signed [SAMPLE_WIDTH-1:0]   o_y
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int IW   = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int AW   = SW + stc_pkg::DRIVE_W;
    localparam int PW   = AW + IW;
    localparam int ARG_FB = SW - 1 + stc_pkg::DRIVE_FRAC;
    localparam int ISH  = ARG_FB + stc_pkg::TANH_RANGE_SH;
    localparam int FSH  = ISH - stc_pkg::FRAC_W;
    localparam int XW   = PW - ISH;
    localparam int WPW  = stc_pkg::TANH_W + stc_pkg::INV_W;
    localparam int SH   = stc_pkg::WET_SH_BASE - SW;
    localparam int WW   = WPW - SH;
    localparam int ETW  = WW + 1;
    localparam int PDW  = SW + 21;
    localparam int SUMW = PDW + 1;
    localparam int MW   = SUMW + stc_pkg::MIX_W;
    localparam int RW   = MW - stc_pkg::ROUND_SH;
    localparam longint unsigned TANH_STEP = (64'd16 << 32) / TANH_TABLE_DEPTH;
    localparam stc_pkg::t_tanh_rom ROM_ALL = stc_pkg::tanh_rom(TANH_STEP, TANH_TABLE_DEPTH);
    localparam logic [IW-1:0] IDX_TOP = IW'(TANH_TABLE_DEPTH);
    localparam logic [RW-1:0] R_HALF  = RW'(1) << (SW - 1);
    localparam logic [RW-1:0] R_MAXP  = R_HALF - RW'(1);
    localparam logic signed [SW-1:0] Y_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] Y_MAX = {1'b0, {(SW-1){1'b1}}};

    logic [stc_pkg::TANH_W-1:0] w_tab [TANH_TABLE_DEPTH+1];

    logic signed [SW-1:0]        r_x1, r_x2, r_x3, r_x4, r_x5;
    logic                        r_neg1, r_neg2, r_neg3, r_neg4;
    logic [AW-1:0]               r_arg1;
    logic [IW-1:0]               r_ia2, r_ib2;
    logic [stc_pkg::FRAC_W-1:0]  r_f2, r_f3;
    logic [stc_pkg::TANH_W-1:0]  r_ta3, r_tb3, r_t4;
    logic signed [ETW-1:0]       r_wet5;
    logic signed [PDW-1:0]       r_pd6, r_pw6;
    logic [SUMW-1:0]             r_sm7;
    logic                        r_sneg7, r_sneg8;
    logic [RW-1:0]               r_r8;
    logic signed [SW-1:0]        r_y9;

    logic                        n_neg1;
    logic [SW-1:0]               n_xm;
    logic [AW-1:0]               n_arg1;
    logic [PW-1:0]               w_pa;
    logic [XW-1:0]               w_pidx;
    logic [IW-1:0]               n_ia2, n_ib2;
    logic [stc_pkg::FRAC_W-1:0]  n_f2;
    logic [stc_pkg::TANH_W-1:0]  n_t4;
    logic [WPW-1:0]              w_wp;
    logic [WW-1:0]               w_wm;
    logic signed [ETW-1:0]       w_wmag, n_wet5;
    logic [stc_pkg::MIX_W-1:0]   w_dry;
    logic signed [PDW-1:0]       n_pd6, n_pw6;
    logic signed [SUMW-1:0]      w_s;
    logic                        n_sneg7;
    logic [SUMW-1:0]             n_sm7;
    logic [MW-1:0]               w_lp;
    logic [RW-1:0]               n_r8;
    logic signed [SW-1:0]        n_y9;

    always_comb begin
        for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
            w_tab[i] = ROM_ALL[i];
        end
    end

    always_comb begin
        // magnitude times drive
        n_neg1 = i_x[SW-1];
        n_xm   = n_neg1 ? $unsigned(-i_x) : $unsigned(i_x);
        n_arg1 = AW'(n_xm) * AW'(i_cfg.drive);

        // table position
        w_pa   = PW'(r_arg1) * PW'(TANH_TABLE_DEPTH);
        w_pidx = w_pa[PW-1:ISH];
        if (w_pidx >= XW'(TANH_TABLE_DEPTH)) begin
            n_ia2 = IDX_TOP;
            n_ib2 = IDX_TOP;
            n_f2  = '0;
        end else begin
            n_ia2 = IW'(w_pidx);
            n_ib2 = IW'(w_pidx) + IW'(1);
            n_f2  = w_pa[FSH +: stc_pkg::FRAC_W];
        end

        n_t4 = stc_pkg::tanh_interp(r_ta3, r_tb3, r_f3);

        // normalize by 1/tanh(drive)
        w_wp   = WPW'(r_t4) * WPW'(i_cfg.inv) + (WPW'(1) << (SH - 1));
        w_wm   = w_wp[WPW-1:SH];
        w_wmag = $signed({1'b0, w_wm});
        n_wet5 = r_neg4 ? -w_wmag : w_wmag;

        // blend
        w_dry = stc_pkg::UNIT_Q16 - i_cfg.mix;
        n_pd6 = PDW'(r_x5) * PDW'($signed({1'b0, w_dry}));
        n_pw6 = PDW'(r_wet5) * PDW'($signed({1'b0, i_cfg.mix}));

        w_s     = SUMW'(r_pd6) + SUMW'(r_pw6);
        n_sneg7 = w_s[SUMW-1];
        n_sm7   = n_sneg7 ? $unsigned(-w_s) : $unsigned(w_s);

        // level, round half away from zero
        w_lp = MW'(r_sm7) * MW'(i_cfg.level) + (MW'(1) << (stc_pkg::ROUND_SH - 1));
        n_r8 = w_lp[MW-1:stc_pkg::ROUND_SH];

        // saturate
        if (r_sneg8) begin
            n_y9 = (r_r8 >= R_HALF) ? Y_MIN : -$signed(r_r8[SW-1:0]);
        end else begin
            n_y9 = (r_r8 > R_MAXP) ? Y_MAX : $signed(r_r8[SW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x1   <= i_x;
            r_neg1 <= n_neg1;
            r_arg1 <= n_arg1;
        end
        if (i_en[1]) begin
            r_x2   <= r_x1;
            r_neg2 <= r_neg1;
            r_ia2  <= n_ia2;
            r_ib2  <= n_ib2;
            r_f2   <= n_f2;
        end
        if (i_en[2]) begin
            r_x3   <= r_x2;
            r_neg3 <= r_neg2;
            r_ta3  <= w_tab[r_ia2];
            r_tb3  <= w_tab[r_ib2];
            r_f3   <= r_f2;
        end
        if (i_en[3]) begin
            r_x4   <= r_x3;
            r_neg4 <= r_neg3;
            r_t4   <= n_t4;
        end
        if (i_en[4]) begin
            r_x5   <= r_x4;
            r_wet5 <= n_wet5;
        end
        if (i_en[5]) begin
            r_pd6  <= n_pd6;
            r_pw6  <= n_pw6;
        end
        if (i_en[6]) begin
            r_sm7   <= n_sm7;
            r_sneg7 <= n_sneg7;
        end
        if (i_en[7]) begin
            r_r8    <= n_r8;
            r_sneg8 <= r_sneg7;
        end
        if (i_en[8]) begin
            r_y9 <= n_y9;
        end
    end

    assign o_y = r_y9;

endmodule

// File: dv/stereo_tanh_soft_clipper_tb.sv
// ----------------------------------------------------------------------------
// stereo_tanh_soft_clipper_tb
// Streams stereo frames through the soft clipper under several drive, mix and
// level settings, with random gaps on both stream sides, and compares every
// output word against a bit-exact fixed-point prediction of the tanh clip,
// the wet/dry blend, the output level and the 24-bit saturation.
// ----------------------------------------------------------------------------
module stereo_tanh_soft_clipper_tb;
    import stc_pkg::*;

    localparam int SAMPLE_W    = SAMPLE_W_DEF;
    localparam int TANH_DEPTH  = TANH_DEPTH_DEF;
    localparam int WORD_W      = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int SETTLE      = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [2*SAMPLE_W-1:0] CORNER_FRAMES [12] = '{
        48'h000000_000000, 48'h800000_7FFFFF, 48'h7FFFFF_800000, 48'h000001_FFFFFF,
        48'hC00000_400000, 48'hFFFF00_000100, 48'hFFF000_001000, 48'h7FFFFF_000000,
        48'hAAAAAA_555555, 48'hE00000_200000, 48'hF80000_080000, 48'h800001_7FFFFE
    };

    typedef longint unsigned u64;

    typedef struct packed {
        logic [SAMPLE_W-1:0] right;
        logic [SAMPLE_W-1:0] left;
    } t_frame;

    class clip_scoreboard;
        u64                  tanh_pts [TANH_DEPTH+1];
        logic [DRIVE_W-1:0]  drive;
        logic [MIX_W-1:0]    mix;
        logic [MIX_W-1:0]    level;
        logic [INV_W-1:0]    inv;
        t_frame              clipped_frames [$];
        int                  errors;

        function new();
            u64 y, term, sum, e, one, num, den;
            int k;
            one  = u64'(1) << 32;
            y    = (u64'(16) << 32) / u64'(TANH_DEPTH);
            term = one;
            sum  = one;
            e    = one;
            for (k = 1; k <= 14; k++) begin
                term = ((term * y) >> 32) / u64'(k);
                if (k % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            for (k = 0; k <= TANH_DEPTH; k++) begin
                if (k > 0) begin
                    e = (e * sum + (u64'(1) << 31)) >> 32;
                end
                num = (one - e) << 23;
                den = one + e;
                tanh_pts[k] = (num + den / 2) / den;
            end
            drive  = DRIVE_RST;
            mix    = MIX_RST;
            level  = LEVEL_RST;
            errors = 0;
            refresh_inverse();
        endfunction

        // interpolated tanh of a magnitude with fb fraction bits, q1.23
        function u64 tanh_at(u64 mag, int fb);
            u64 p, idx, f, a, b;
            p   = (mag * u64'(TANH_DEPTH)) >> 3;
            idx = p >> fb;
            if (idx >= u64'(TANH_DEPTH)) begin
                return tanh_pts[TANH_DEPTH];
            end
            if (fb >= 16) begin
                f = (p >> (fb - 16)) & 64'hFFFF;
            end else begin
                f = (p << (16 - fb)) & 64'hFFFF;
            end
            a = tanh_pts[idx];
            b = tanh_pts[idx + 1];
            if (b < a) begin
                b = a;
            end
            return a + (((b - a) * f + 64'd32768) >> 16);
        endfunction

        function void refresh_inverse();
            u64 t, q;
            t = tanh_at(u64'(drive), DRIVE_FRAC);
            if (t == 0) begin
                inv = INV_MAX;
            end else begin
                q   = ((u64'(1) << 39) + t / 2) / t;
                inv = (q > u64'(INV_MAX)) ? INV_MAX : INV_W'(q);
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            logic [DRIVE_W-1:0] d;
            case (idx)
                CFG_DRIVE: begin
                    d = val[DRIVE_W-1:0];
                    if (d < DRIVE_MIN) d = DRIVE_MIN;
                    if (d > DRIVE_MAX) d = DRIVE_MAX;
                    drive = d;
                    refresh_inverse();
                end
                CFG_MIX: begin
                    mix = (val > UNIT_Q16) ? UNIT_Q16 : val;
                end
                CFG_LEVEL: begin
                    level = (val > UNIT_Q16) ? UNIT_Q16 : val;
                end
                default: ;
            endcase
        endfunction

        function logic [SAMPLE_W-1:0] clip_sample(logic [SAMPLE_W-1:0] raw);
            longint x, wet, s;
            u64     xm, t, wm, sm, r, maxp;
            bit     neg, sneg;
            x    = longint'($signed(raw));
            neg  = x < 0;
            xm   = neg ? u64'(-x) : u64'(x);
            t    = tanh_at(xm * u64'(drive), SAMPLE_W + 9);
            wm   = (t * u64'(inv) + (u64'(1) << (WET_SH_BASE - SAMPLE_W - 1)))
                   >> (WET_SH_BASE - SAMPLE_W);
            wet  = neg ? -longint'(wm) : longint'(wm);
            s    = x * longint'(UNIT_Q16 - mix) + wet * longint'(mix);
            sneg = s < 0;
            sm   = sneg ? u64'(-s) : u64'(s);
            r    = (sm * u64'(level) + (u64'(1) << 31)) >> 32;
            maxp = (u64'(1) << (SAMPLE_W - 1)) - 1;
            if (sneg) begin
                if (r > maxp + 1) r = maxp + 1;
                return SAMPLE_W'(u64'(0) - r);
            end
            if (r > maxp) r = maxp;
            return SAMPLE_W'(r);
        endfunction

        function void take_frame(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
            t_frame f;
            f.left  = clip_sample(l);
            f.right = clip_sample(r);
            clipped_frames.push_back(f);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("%s", msg);
        endfunction

        function void check_frame(t_frame got);
            t_frame want;
            if (clipped_frames.size() == 0) begin
                flag($sformatf("unexpected output word %h", got));
                return;
            end
            want = clipped_frames.pop_front();
            if (got.left !== want.left)
                flag($sformatf("left_out mismatch: expected %0d got %0d",
                               $signed(want.left), $signed(got.left)));
            if (got.right !== want.right)
                flag($sformatf("right_out mismatch: expected %0d got %0d",
                               $signed(want.right), $signed(got.right)));
        endfunction

        function int pending();
            return clipped_frames.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [WORD_W-1:0]      i_s_axis_tdata = '0;  // left_in, right_in
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [WORD_W-1:0]      o_m_axis_tdata;       // left_out, right_out
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    clip_scoreboard sb;
    bit             quiet = 1'b0;
    int             sink_hold = 0;
    int             cycles = 0;

    stereo_tanh_soft_clipper DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("stereo_tanh_soft_clipper test failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       v = '0;
                    1:       v = {1'b0, {(SAMPLE_W-1){1'b1}}};
                    2:       v = {1'b1, {(SAMPLE_W-1){1'b0}}};
                    3:       v = '1;
                    default: v = SAMPLE_W'(1);
                endcase
            end
            1, 2, 3: begin
                v = SAMPLE_W'($urandom) >> $urandom_range(0, SAMPLE_W - 1);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            default: v = SAMPLE_W'($urandom);
        endcase
        return v;
    endfunction

    // output side: check accepted words, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_frame(o_m_axis_tdata);
        end
        if (sink_hold > 0) begin
            sink_hold       <= sink_hold - 1;
            i_m_axis_tready <= 1'b0;
        end else if (quiet || $urandom_range(0, 3) != 0) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            i_m_axis_tready <= 1'b0;
            sink_hold       <= pick_gap();
        end
    end

    task automatic send_frame(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {r, l};
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
        sb.take_frame(l, r);
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_frame(pick_sample(), pick_sample());
        end
    endtask

    task automatic send_corners();
        for (int n = 0; n < 12; n++) begin
            send_frame(CORNER_FRAMES[n][SAMPLE_W-1:0], CORNER_FRAMES[n][2*SAMPLE_W-1:SAMPLE_W]);
        end
    endtask

    // drop valid and wait until every word is back and the pipe is empty
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        while (!o_s_axis_tready) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] d, input logic [CFG_DATA_W-1:0] m,
                             input logic [CFG_DATA_W-1:0] l, input int count, input bit q);
        settle();
        write_reg(CFG_DRIVE, d);
        write_reg(CFG_MIX, m);
        write_reg(CFG_LEVEL, l);
        quiet = q;
        send_random(count);
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings
        send_corners();
        send_random(80);

        // hardest clip, full wet, full level: saturation
        run_phase(CFG_DATA_W'(DRIVE_MAX), UNIT_Q16, UNIT_Q16, 0, 1'b0);
        send_corners();
        send_random(140);

        run_phase(CFG_DATA_W'(DRIVE_MIN), '0, UNIT_Q16, 110, 1'b1);
        run_phase('0, 17'h1FFFF, '0, 70, 1'b0);

        // pause mid-stream until the pipe drains
        run_phase(17'h0FFFF, 17'd32768, 17'h1FFFF, 70, 1'b0);
        settle();
        send_random(70);

        // bit 16 is dropped for drive
        run_phase(17'h10800, CFG_DATA_W'($urandom_range(0, 70000)),
                  CFG_DATA_W'($urandom_range(0, 70000)), 140, 1'b0);

        for (int n = 0; n < 3; n++) begin
            run_phase(CFG_DATA_W'($urandom_range(0, 131071)),
                      CFG_DATA_W'($urandom_range(0, 70000)),
                      CFG_DATA_W'($urandom_range(0, 70000)), 120,
                      1'($urandom_range(0, 1)));
        end

        // unknown index must leave everything alone
        settle();
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        run_phase(CFG_DATA_W'(DRIVE_RST), MIX_RST, LEVEL_RST, 90, 1'b0);

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("stereo_tanh_soft_clipper test passed");
        end else begin
            $display("stereo_tanh_soft_clipper test failed");
        end
        $finish;
    end

endmodule

// File: files.f
design/stc_pkg.sv
design/stc_lane.sv
design/stereo_tanh_soft_clipper.sv
dv/stereo_tanh_soft_clipper_tb.sv
